// ===== rtl/tscrf_pkg.sv =====
`timescale 1ns / 1ps
package tscrf_pkg;

   localparam int MAX_COLUMNS  = 128;
   localparam int MAX_ROWS     = 64;
   localparam int COL_W        = 7;
   localparam int ROW_W        = 6;
   localparam int COLS_W       = 8;
   localparam int ROWS_W       = 7;
   localparam int ADDR_W       = COL_W + ROW_W;
   localparam int SHADOW_DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int CELL_W       = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 8;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = 1;
   localparam int QCNT_W       = 2;

   localparam logic [7:0]        SPACE_CODE = 8'h20;
   localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMNS = 1'b0,
      CSR_ROWS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic [7:0] attr_code;
      logic       frame_start;
      logic       force_redraw;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] out_column;
      logic [ROW_W-1:0] out_row;
      logic [7:0]       shown_char;
      logic [7:0]       run_attr;
      logic             run_last;
   } rsp_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic [7:0]       shown_char;
      logic [7:0]       attr;
   } cell_type;

   // classified cell handed from the front to the back
   typedef struct packed {
      logic     emit;
      logic     row_end;
      logic     frame_start;
      cell_type info;
   } entry_type;

   function automatic logic [7:0] shown_char_of(input logic [7:0] ch);
      return (ch == 8'h00) ? SPACE_CODE : ch;
   endfunction

endpackage

// ===== rtl/tscrf_ram.sv =====
`timescale 1ns / 1ps
module tscrf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tscrf_front.sv =====
`timescale 1ns / 1ps
module tscrf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tscrf_pkg::req_type                req_data,
   input  logic [tscrf_pkg::COLS_W-1:0]      cols,
   input  logic [tscrf_pkg::ROWS_W-1:0]      rows,
   input  logic                              clear_start,
   output logic                              q_push,
   output tscrf_pkg::entry_type              q_data,
   input  logic                              q_full
);

   logic                             clear_ff, clear_in;
   logic [tscrf_pkg::ADDR_W-1:0]     clear_cnt_ff, clear_cnt_in;
   logic [tscrf_pkg::COL_W-1:0]      scan_col_ff, scan_col_in;
   logic [tscrf_pkg::ROW_W-1:0]      scan_row_ff, scan_row_in;
   logic                             s1_valid_ff, s1_valid_in;
   logic [tscrf_pkg::ADDR_W-1:0]     s1_addr_ff;
   logic [tscrf_pkg::CELL_W-1:0]     s1_cell_ff;
   logic                             s1_force_ff;
   logic                             s1_row_end_ff;
   logic                             s1_fstart_ff;
   tscrf_pkg::cell_type              s1_info_ff;
   logic                             fwd_valid_ff, fwd_valid_in;
   logic [tscrf_pkg::ADDR_W-1:0]     fwd_addr_ff;
   logic [tscrf_pkg::CELL_W-1:0]     fwd_cell_ff;

   logic [tscrf_pkg::COL_W-1:0]      col_at;
   logic [tscrf_pkg::ROW_W-1:0]      row_at;
   logic [tscrf_pkg::COLS_W-1:0]     col_inc;
   logic [tscrf_pkg::ROWS_W-1:0]     row_inc;
   logic                             row_end;
   logic                             accept;
   logic                             s1_go;
   logic [tscrf_pkg::CELL_W-1:0]     shadow_q;
   logic [tscrf_pkg::CELL_W-1:0]     shadow_old;
   logic                             emit;
   logic                             ram_we;
   logic [tscrf_pkg::ADDR_W-1:0]     ram_waddr;
   logic [tscrf_pkg::CELL_W-1:0]     ram_wdata;

   // scan position of the cell on the request port
   always_comb begin
      col_at = req_data.frame_start ? '0 : scan_col_ff;
      row_at = req_data.frame_start ? '0 : scan_row_ff;
      if ({1'b0, col_at} >= cols || {1'b0, row_at} >= rows) begin
         col_at = '0;
         row_at = '0;
      end
      col_inc = {1'b0, col_at} + 1'b1;
      row_inc = {1'b0, row_at} + 1'b1;
      row_end = (col_inc >= cols);
   end

   assign s1_go     = s1_valid_ff && !q_full;
   assign req_ready = !clear_ff && (!s1_valid_ff || !q_full);
   assign accept    = req_valid && req_ready;

   // the last write is always the newest value of its address
   assign shadow_old = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_cell_ff : shadow_q;
   assign emit       = s1_force_ff || (shadow_old != s1_cell_ff);

   assign ram_we    = clear_ff || (s1_go && emit);
   assign ram_waddr = clear_ff ? clear_cnt_ff : s1_addr_ff;
   assign ram_wdata = clear_ff ? '0 : s1_cell_ff;

   tscrf_ram #(
      .WIDTH (tscrf_pkg::CELL_W),
      .DEPTH (tscrf_pkg::SHADOW_DEPTH)
   ) u_shadow (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr ({row_at, col_at}),
      .rdata (shadow_q)
   );

   assign q_push = s1_go;
   always_comb begin
      q_data.emit        = emit;
      q_data.row_end     = s1_row_end_ff;
      q_data.frame_start = s1_fstart_ff;
      q_data.info        = s1_info_ff;
   end

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      scan_col_in  = scan_col_ff;
      scan_row_in  = scan_row_ff;
      s1_valid_in  = s1_valid_ff;
      fwd_valid_in = fwd_valid_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == tscrf_pkg::ADDR_W'(tscrf_pkg::SHADOW_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
      if (s1_go) begin
         s1_valid_in = 1'b0;
         if (emit) begin
            fwd_valid_in = 1'b1;
         end
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         if (row_end) begin
            scan_col_in = '0;
            scan_row_in = (row_inc >= rows) ? '0 : row_inc[tscrf_pkg::ROW_W-1:0];
         end else begin
            scan_col_in = col_inc[tscrf_pkg::COL_W-1:0];
            scan_row_in = row_at;
         end
      end
      if (clear_start) begin
         clear_in     = 1'b1;
         clear_cnt_in = '0;
         scan_col_in  = '0;
         scan_row_in  = '0;
         s1_valid_in  = 1'b0;
         fwd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         scan_col_ff  <= '0;
         scan_row_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         scan_col_ff  <= scan_col_in;
         scan_row_ff  <= scan_row_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff            <= {row_at, col_at};
         s1_cell_ff            <= {req_data.attr_code, req_data.char_code};
         s1_force_ff           <= req_data.force_redraw;
         s1_row_end_ff         <= row_end;
         s1_fstart_ff          <= req_data.frame_start;
         s1_info_ff.column     <= col_at;
         s1_info_ff.row        <= row_at;
         s1_info_ff.shown_char <= tscrf_pkg::shown_char_of(req_data.char_code);
         s1_info_ff.attr       <= req_data.attr_code;
      end
      if (s1_go && emit) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_cell_ff <= s1_cell_ff;
      end
   end

endmodule

// ===== rtl/tscrf_queue.sv =====
`timescale 1ns / 1ps
module tscrf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tscrf_pkg::entry_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output tscrf_pkg::entry_type head
);

   tscrf_pkg::entry_type               entries_ff [tscrf_pkg::QUEUE_DEPTH];
   logic [tscrf_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tscrf_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tscrf_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full      = (count_ff == tscrf_pkg::QCNT_W'(tscrf_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tscrf_back.sv =====
`timescale 1ns / 1ps
module tscrf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear_start,
   input  logic                 q_valid,
   input  tscrf_pkg::entry_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tscrf_pkg::rsp_type   rsp_data
);

   logic                 pend_valid_ff, pend_valid_in;
   tscrf_pkg::cell_type  pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tscrf_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                 slot_free;
   logic                 out_load;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      q_pop         = 1'b0;
      out_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (q_valid) begin
         if (pend_valid_ff) begin
            if (slot_free) begin
               // release the held cell; its run ends unless this cell continues it
               out_load               = 1'b1;
               rsp_data_in.out_column = pend_ff.column;
               rsp_data_in.out_row    = pend_ff.row;
               rsp_data_in.shown_char = pend_ff.shown_char;
               rsp_data_in.run_attr   = pend_ff.attr;
               rsp_data_in.run_last   = !q_head.emit || (pend_ff.attr != q_head.info.attr)
                                        || q_head.frame_start;
               pend_valid_in          = 1'b0;
               if (q_head.emit && !q_head.row_end) begin
                  pend_valid_in = 1'b1;
                  pend_in       = q_head.info;
                  q_pop         = 1'b1;
               end else if (!q_head.emit) begin
                  q_pop = 1'b1;
               end
               // a row-end cell stays at the head and goes out on its own once the response slot is free
            end
         end else if (q_head.emit && q_head.row_end) begin
            if (slot_free) begin
               out_load               = 1'b1;
               rsp_data_in.out_column = q_head.info.column;
               rsp_data_in.out_row    = q_head.info.row;
               rsp_data_in.shown_char = q_head.info.shown_char;
               rsp_data_in.run_attr   = q_head.info.attr;
               rsp_data_in.run_last   = 1'b1;
               q_pop                  = 1'b1;
            end
         end else if (q_head.emit) begin
            pend_valid_in = 1'b1;
            pend_in       = q_head.info;
            q_pop         = 1'b1;
         end else begin
            q_pop = 1'b1;
         end
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      // drop the held cell on a screen size change
      if (clear_start) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/text_screen_changed_run_finder.sv =====
`timescale 1ns / 1ps
// Text screen changed-run finder.
// Request channel (req_valid/req_ready/req_data) takes one screen cell per
// transaction in raster order; response channel (rsp_valid/rsp_ready/rsp_data)
// returns each changed cell with its position, shown character, attribute and
// a run_last flag. The csr_ port writes the column count (index 0) and the row
// count (index 1) with no wait.
// Throughput: one cell per cycle while req_ready is high; it is low during the
// clear sweep and while the queue is full. A cell at the end of its row that also
// releases a held cell gives two responses and holds the run builder until both
// are sent; the two-entry queue between the classifier and the run builder soaks
// up an occasional one, but when every row ends that way the queue fills and req_ready drops.
// A transaction passes the classifier register, the queue and the response
// register before its response is presented. A changed cell not at a row end
// is held until the next cell decides whether its run continues.
// At reset, and after any write that changes a size register, the shadow
// screen is cleared by a sweep over all 8192 entries, one entry per cycle,
// during which req_ready is low; register writes are still taken.
// When rsp_ready is low the response register holds, the queue fills and
// req_ready drops; no transaction is lost.
module text_screen_changed_run_finder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tscrf_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tscrf_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_we,
   input  logic [tscrf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tscrf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [tscrf_pkg::COLS_W-1:0] cols_ff, cols_in;
   logic [tscrf_pkg::ROWS_W-1:0] rows_ff, rows_in;
   logic [tscrf_pkg::COLS_W-1:0] cols_eff;
   logic [tscrf_pkg::ROWS_W-1:0] rows_eff;
   logic                         clear_start;
   logic                         q_push;
   logic                         q_full;
   logic                         q_pop;
   logic                         q_valid;
   tscrf_pkg::entry_type         q_data;
   tscrf_pkg::entry_type         q_head;

   always_comb begin
      cols_in     = cols_ff;
      rows_in     = rows_ff;
      clear_start = 1'b0;
      if (csr_we) begin
         if (csr_index == tscrf_pkg::CSR_COLUMNS) begin
            if (csr_wdata != cols_ff) begin
               cols_in     = csr_wdata;
               clear_start = 1'b1;
            end
         end else if (csr_index == tscrf_pkg::CSR_ROWS) begin
            if (csr_wdata[tscrf_pkg::ROWS_W-1:0] != rows_ff) begin
               rows_in     = csr_wdata[tscrf_pkg::ROWS_W-1:0];
               clear_start = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= tscrf_pkg::COLS_RESET;
         rows_ff <= tscrf_pkg::ROWS_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // limit sizes to 1..max
   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = tscrf_pkg::COLS_W'(1);
      end else if (cols_ff > tscrf_pkg::COLS_W'(tscrf_pkg::MAX_COLUMNS)) begin
         cols_eff = tscrf_pkg::COLS_W'(tscrf_pkg::MAX_COLUMNS);
      end else begin
         cols_eff = cols_ff;
      end
      if (rows_ff == '0) begin
         rows_eff = tscrf_pkg::ROWS_W'(1);
      end else if (rows_ff > tscrf_pkg::ROWS_W'(tscrf_pkg::MAX_ROWS)) begin
         rows_eff = tscrf_pkg::ROWS_W'(tscrf_pkg::MAX_ROWS);
      end else begin
         rows_eff = rows_ff;
      end
   end

   tscrf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .cols        (cols_eff),
      .rows        (rows_eff),
      .clear_start (clear_start),
      .q_push      (q_push),
      .q_data      (q_data),
      .q_full      (q_full)
   );

   tscrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   tscrf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .clear_start (clear_start),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== tb/text_screen_changed_run_finder_checker.sv =====
`timescale 1ns / 1ps
module text_screen_changed_run_finder_checker
   import tscrf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     expected_count,
   output int                     fail_count
);

   logic [CELL_W-1:0] shadow [SHADOW_DEPTH];
   int                scan_col;
   int                scan_row;
   logic              held_valid;
   rsp_type           held_cell;
   logic [COLS_W-1:0] cols_reg;
   logic [ROWS_W-1:0] rows_reg;
   rsp_type           cells_due [$];
   int                errors = 0;

   function automatic int clamp_count(input int v, input int top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic void clear_screen();
      foreach (shadow[i]) shadow[i] = '0;
      scan_col = 0;
      scan_row = 0;
      held_valid = 1'b0;
      held_cell = '0;
   endfunction

   function automatic void write_size(input logic [CSR_INDEX_W-1:0] index,
                                      input logic [CSR_DATA_W-1:0] value);
      case (csr_index_type'(index))
         CSR_COLUMNS: begin
            if (value != cols_reg) begin
               cols_reg = value;
               clear_screen();
            end
         end
         CSR_ROWS: begin
            if (value[ROWS_W-1:0] != rows_reg) begin
               rows_reg = value[ROWS_W-1:0];
               clear_screen();
            end
         end
         default: ;
      endcase
   endfunction

   // compare one cell against the shadow and queue the responses it releases
   function automatic void scan_cell(input req_type r);
      int                cols;
      int                rows;
      int                idx;
      logic [CELL_W-1:0] cell_word;
      logic              emit;
      rsp_type           res;
      cols = clamp_count(int'(cols_reg), MAX_COLUMNS);
      rows = clamp_count(int'(rows_reg), MAX_ROWS);
      if (r.frame_start) begin
         scan_col = 0;
         scan_row = 0;
      end
      if (scan_col >= cols || scan_row >= rows) begin
         scan_col = 0;
         scan_row = 0;
      end
      idx = scan_row * MAX_COLUMNS + scan_col;
      cell_word = {r.attr_code, r.char_code};
      emit = r.force_redraw || (shadow[idx] != cell_word);
      if (held_valid) begin
         res = held_cell;
         res.run_last = !emit || (held_cell.run_attr != r.attr_code) || r.frame_start;
         cells_due.push_back(res);
         held_valid = 1'b0;
      end
      if (emit) begin
         shadow[idx] = cell_word;
         res.out_column = COL_W'(scan_col);
         res.out_row    = ROW_W'(scan_row);
         res.shown_char = (r.char_code == 8'h00) ? SPACE_CODE : r.char_code;
         res.run_attr   = r.attr_code;
         res.run_last   = 1'b1;
         // a row end closes its run at once
         if (scan_col + 1 >= cols) begin
            cells_due.push_back(res);
         end else begin
            held_cell = res;
            held_valid = 1'b1;
         end
      end
      scan_col++;
      if (scan_col >= cols) begin
         scan_col = 0;
         scan_row++;
         if (scan_row >= rows) scan_row = 0;
      end
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_result(input rsp_type got);
      rsp_type want;
      if (cells_due.size() == 0) begin
         $error("response with none expected: column %0d row %0d char %0d",
                got.out_column, got.out_row, got.shown_char);
         errors++;
      end else begin
         want = cells_due.pop_front();
         compare_field("out_column", want.out_column, got.out_column);
         compare_field("out_row", want.out_row, got.out_row);
         compare_field("shown_char", want.shown_char, got.shown_char);
         compare_field("run_attr", want.run_attr, got.run_attr);
         compare_field("run_last", want.run_last, got.run_last);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cols_reg = COLS_RESET;
         rows_reg = ROWS_RESET;
         clear_screen();
         cells_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (csr_we) write_size(csr_index, csr_wdata);
         if (req_valid && req_ready) scan_cell(req_data);
      end
      expected_count <= cells_due.size();
      fail_count <= errors;
   end

endmodule

// ===== tb/text_screen_changed_run_finder_tb.sv =====
`timescale 1ns / 1ps
module text_screen_changed_run_finder_tb
   import tscrf_pkg::*;
();

   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT  = 30000;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASES       = 9;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_SELDOM} ready_mode_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     expected_count;
   int                     fail_count;

   // screen sizes of the random phases, the extremes and out-of-range values among them
   int phase_cols [PHASES]  = '{4, 1, 0, 128, 1, 255, 7, 7, 2};
   int phase_rows [PHASES]  = '{3, 1, 0, 2, 64, 127, 5, 5, 65};
   int phase_items [PHASES] = '{150, 60, 60, 300, 130, 150, 150, 150, 100};

   logic [15:0] frame_cells [SHADOW_DEPTH];
   int          frame_pos = 0;
   int          frame_size = 80 * 25;
   logic [7:0]  cols_now = COLS_RESET;
   logic [6:0]  rows_now = ROWS_RESET;
   logic [7:0]  last_attr = 8'h07;
   int          burst_left = 0;
   int          cells_sent = 0;

   text_screen_changed_run_finder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   text_screen_changed_run_finder_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .expected_count (expected_count),
      .fail_count     (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int clamp_count(input int v, input int top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // offer one transaction, inside a burst or after a random gap
   task automatic send_cell(input req_type r);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      end
      burst_left--;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      cells_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write both size registers back to back; the second lands during the clear sweep when the first changed the size
   task automatic set_size(input logic [7:0] cols, input logic [6:0] rows);
      if (cols != cols_now || rows != rows_now) begin
         foreach (frame_cells[i]) frame_cells[i] = '0;
         frame_pos = 0;
      end
      cols_now = cols;
      rows_now = rows;
      frame_size = clamp_count(int'(cols), MAX_COLUMNS) * clamp_count(int'(rows), MAX_ROWS);
      csr_we <= 1'b1;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= {1'($urandom), rows};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // resend the previous frame with some cells changed, so runs break on unchanged cells
   task automatic make_cell(output req_type r, input int change_pct);
      logic [15:0] c;
      logic        fs;
      fs = ($urandom_range(0, 40) == 0);
      if (fs) frame_pos = 0;
      c = frame_cells[frame_pos];
      if ($urandom_range(0, 9) == 0) begin
         c = 16'($urandom);
      end else if ($urandom_range(0, 99) < change_pct) begin
         c[7:0] = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
         c[15:8] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : last_attr;
      end
      last_attr = c[15:8];
      frame_cells[frame_pos] = c;
      frame_pos = (frame_pos + 1 >= frame_size) ? 0 : frame_pos + 1;
      r.char_code = c[7:0];
      r.attr_code = c[15:8];
      r.frame_start = fs;
      r.force_redraw = ($urandom_range(0, 11) == 0);
   endtask

   initial begin
      req_type r;
      int      pct;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // default size: unchanged, forced, extremes, run continue and break, frame start
      send_cell('{8'h00, 8'h00, 1'b0, 1'b0});
      send_cell('{8'h00, 8'h00, 1'b0, 1'b1});
      send_cell('{8'hFF, 8'hFF, 1'b0, 1'b0});
      send_cell('{8'h41, 8'hFF, 1'b0, 1'b0});
      send_cell('{8'h00, 8'h00, 1'b0, 1'b0});
      send_cell('{8'h20, 8'h80, 1'b0, 1'b0});
      send_cell('{8'h42, 8'h80, 1'b1, 1'b0});
      send_cell('{8'h42, 8'h80, 1'b1, 1'b0});
      send_cell('{8'h01, 8'h7F, 1'b0, 1'b1});
      drain();

      // tiny screen: row ends, pairs of responses, wrap, held cell dropped by resize
      set_size(8'd3, 7'd2);
      send_cell('{8'h10, 8'h01, 1'b0, 1'b0});
      send_cell('{8'h11, 8'h01, 1'b0, 1'b0});
      send_cell('{8'h12, 8'h01, 1'b0, 1'b0});
      send_cell('{8'h13, 8'h02, 1'b0, 1'b0});
      send_cell('{8'h14, 8'h03, 1'b0, 1'b0});
      send_cell('{8'h00, 8'h03, 1'b0, 1'b0});
      send_cell('{8'h10, 8'h01, 1'b0, 1'b0});
      send_cell('{8'hAA, 8'h01, 1'b0, 1'b1});
      send_cell('{8'h12, 8'h01, 1'b1, 1'b0});
      send_cell('{8'h11, 8'h01, 1'b0, 1'b0});
      send_cell('{8'h12, 8'h01, 1'b0, 1'b1});
      send_cell('{8'h55, 8'hAA, 1'b1, 1'b1});
      send_cell('{8'h00, 8'h00, 1'b0, 1'b0});

      foreach (phase_cols[p]) begin
         drain();
         set_size(8'(phase_cols[p]), 7'(phase_rows[p]));
         pct = $urandom_range(10, 60);
         repeat (phase_items[p]) begin
            make_cell(r, pct);
            send_cell(r);
         end
      end
      drain();

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // response side: randomly chosen stall patterns, one long hold-off
   initial begin
      ready_mode_type mode;
      int             mode_left;
      bit             held_off;
      mode = READY_ALWAYS;
      mode_left = 0;
      held_off = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && cells_sent >= HOLD_AT) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(8, 64);
         end
         mode_left--;
         case (mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
            default:      rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // end the run when no transaction moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== text_screen_changed_run_finder.f =====
rtl/tscrf_pkg.sv
rtl/tscrf_ram.sv
rtl/tscrf_front.sv
rtl/tscrf_queue.sv
rtl/tscrf_back.sv
rtl/text_screen_changed_run_finder.sv
tb/text_screen_changed_run_finder_checker.sv
tb/text_screen_changed_run_finder_tb.sv
